@@ rtl/stl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token kind codes and character classes for the token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int POSITION_BITS     = 16;
   localparam int KEYWORD_MAX_CHARS = 5;
   localparam int PREFIX_BITS       = 8 * KEYWORD_MAX_CHARS;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_ABITS       = 2;

   localparam logic [15:0] LEN_MAX   = 16'hFFFF;
   localparam logic [15:0] TALLY_MAX = 16'hFFFF;

   // token kinds
   localparam logic [5:0] KIND_OP_BASE = 6'd16;
   localparam logic [5:0] KIND_STRING  = 6'd32;
   localparam logic [5:0] KIND_INTEGER = 6'd33;
   localparam logic [5:0] KIND_FLOAT   = 6'd34;
   localparam logic [5:0] KIND_IDENT   = 6'd35;
   localparam logic [5:0] KIND_KEY_BASE = 6'd36;
   localparam logic [5:0] KIND_END     = 6'd47;
   localparam logic [5:0] KIND_ERROR   = 6'd48;

   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // one token with its slot information; a queue entry holds a pair of these
   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic        last;
   } token_type;

   // what the front hands the back for one byte
   typedef struct packed {
      logic      two;     // both tokens present
      token_type first;
      token_type second;
   } pair_type;

   function automatic logic is_numeral(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
             || (b == CH_UNDER);
   endfunction

   // punctuator index, bit 4 set when not a punctuator
   function automatic logic [4:0] punct_index(input logic [7:0] b);
      case (b)
         8'h28: return 5'd0;
         8'h29: return 5'd1;
         8'h7B: return 5'd2;
         8'h7D: return 5'd3;
         8'h5B: return 5'd4;
         8'h5D: return 5'd5;
         8'h2E: return 5'd6;
         8'h2C: return 5'd7;
         8'h3B: return 5'd8;
         8'h21: return 5'd9;
         8'h3F: return 5'd10;
         8'h24: return 5'd11;
         8'h25: return 5'd12;
         8'h40: return 5'd13;
         8'h23: return 5'd14;
         8'h5C: return 5'd15;
         default: return 5'd16;
      endcase
   endfunction

   // one-byte operator offset, bit 4 set when not an operator
   function automatic logic [4:0] single_op(input logic [7:0] b);
      case (b)
         8'h3D: return 5'd0;
         8'h2D: return 5'd3;
         8'h2B: return 5'd6;
         8'h2A: return 5'd8;
         8'h2F: return 5'd10;
         8'h7C: return 5'd12;
         8'h26: return 5'd14;
         default: return 5'd16;
      endcase
   endfunction

   function automatic logic [4:0] double_op(input logic [7:0] op, input logic [7:0] b);
      logic [4:0] r;
      r = 5'd16;
      if (op == CH_EQ && b == CH_EQ) r = 5'd1;
      if (op == CH_EQ && b == CH_GT) r = 5'd2;
      if (op == 8'h2D && b == CH_EQ) r = 5'd4;
      if (op == 8'h2D && b == CH_GT) r = 5'd5;
      if (op == 8'h2B && b == CH_EQ) r = 5'd7;
      if (op == 8'h2A && b == CH_EQ) r = 5'd9;
      if (op == CH_SLASH && b == CH_EQ) r = 5'd11;
      if (op == 8'h7C && b == 8'h7C) r = 5'd13;
      if (op == 8'h26 && b == 8'h26) r = 5'd15;
      return r;
   endfunction

   // keyword lookup on the packed word prefix
   function automatic logic [5:0] word_kind(input logic [PREFIX_BITS-1:0] p,
                                            input logic [15:0] len);
      logic [5:0] k;
      k = KIND_IDENT;
      if (len == 16'd3 && p == PREFIX_BITS'(24'h6C6574)) k = KIND_KEY_BASE;
      if (len == 16'd3 && p == PREFIX_BITS'(24'h666F72)) k = KIND_KEY_BASE + 6'd1;
      if (len == 16'd4 && p == PREFIX_BITS'(32'h66756E63)) k = KIND_KEY_BASE + 6'd2;
      if (len == 16'd4 && p == PREFIX_BITS'(32'h656C7365)) k = KIND_KEY_BASE + 6'd3;
      if (len == 16'd4 && p == PREFIX_BITS'(32'h7468656E)) k = KIND_KEY_BASE + 6'd4;
      if (len == 16'd4 && p == PREFIX_BITS'(32'h6C6F6F70)) k = KIND_KEY_BASE + 6'd5;
      if (len == 16'd4 && p == PREFIX_BITS'(32'h77697468)) k = KIND_KEY_BASE + 6'd6;
      if (len == 16'd5 && p == PREFIX_BITS'(40'h636F6E7374)) k = KIND_KEY_BASE + 6'd7;
      if (len == 16'd5 && p == PREFIX_BITS'(40'h7573696E67)) k = KIND_KEY_BASE + 6'd8;
      if (len == 16'd5 && p == PREFIX_BITS'(40'h6D61746368)) k = KIND_KEY_BASE + 6'd9;
      if (len == 16'd5 && p == PREFIX_BITS'(40'h627265616B)) k = KIND_KEY_BASE + 6'd10;
      return k;
   endfunction

endpackage

@@ rtl/stl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front
// Scanner: takes one byte a beat and produces up to two tokens for it.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       byte_ready,
   output logic       pair_valid,
   output pair_type   pair_data,
   input  logic       space_ok
);

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_OPER, MODE_WORD, MODE_NUMBER, MODE_STRING, MODE_COMMENT
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [7:0]               op_ff, op_in;
   logic [PREFIX_BITS-1:0]   prefix_ff, prefix_in;
   logic [POSITION_BITS-1:0] start_ff, start_in, pos_ff;
   logic [15:0]              len_ff, len_in;
   logic                     dot_ff, dot_in;

   logic      take;
   logic      n_first, n_second, flush_tok, begin_now;
   token_type flush_t, begin_t, direct_t;
   logic      begin_emit, direct_emit;
   logic [4:0] pi, so, dop, pend_op;
   logic [15:0] len_grow;

   assign byte_ready = space_ok;
   assign take       = byte_valid && space_ok;
   assign len_grow   = (len_ff == LEN_MAX) ? len_ff : len_ff + 16'd1;
   assign pend_op    = single_op(op_ff);

   always_comb begin
      // token that the pending scan produces when cut short
      flush_t        = '0;
      flush_t.offset = 16'(start_ff);
      flush_t.length = len_ff;
      flush_tok      = 1'b0;
      unique case (mode_ff)
         MODE_OPER: begin
            flush_tok = 1'b1;
            flush_t.kind = KIND_OP_BASE + {2'b00, pend_op[3:0]};
            flush_t.length = 16'd1;
         end
         MODE_WORD: begin
            flush_tok = 1'b1;
            flush_t.kind = (len_ff > 16'(KEYWORD_MAX_CHARS)) ? KIND_IDENT
                           : word_kind(prefix_ff, len_ff);
         end
         MODE_NUMBER: begin
            flush_tok = 1'b1;
            flush_t.kind = dot_ff ? KIND_FLOAT : KIND_INTEGER;
         end
         MODE_STRING: begin
            flush_tok = 1'b1;
            flush_t.kind = KIND_ERROR;
         end
         default: flush_tok = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      op_in     = op_ff;
      prefix_in = prefix_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      dot_in    = dot_ff;
      begin_now = 1'b0;
      n_first   = 1'b0;
      direct_emit = 1'b0;
      direct_t  = '0;
      pi  = punct_index(byte_data);
      so  = single_op(byte_data);
      dop = double_op(op_ff, byte_data);

      unique case (mode_ff)
         MODE_OPER: begin
            if (op_ff == CH_SLASH && byte_data == CH_SLASH) mode_in = MODE_COMMENT;
            else if (!dop[4]) begin
               direct_emit = 1'b1;
               direct_t.kind = KIND_OP_BASE + {2'b00, dop[3:0]};
               direct_t.offset = 16'(start_ff);
               direct_t.length = 16'd2;
               mode_in = MODE_IDLE;
            end else begin
               n_first = 1'b1;
               begin_now = 1'b1;
            end
         end
         MODE_WORD: begin
            if (is_letter(byte_data) || is_numeral(byte_data)) begin
               if (len_ff < 16'(KEYWORD_MAX_CHARS))
                  prefix_in = {prefix_ff[PREFIX_BITS-9:0], byte_data};
               len_in = len_grow;
            end else begin
               n_first = 1'b1;
               begin_now = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_numeral(byte_data) || byte_data == CH_UNDER || byte_data == CH_DOT) begin
               if (byte_data == CH_DOT) dot_in = 1'b1;
               len_in = len_grow;
            end else begin
               n_first = 1'b1;
               begin_now = 1'b1;
            end
         end
         MODE_STRING: begin
            len_in = len_grow;
            if (byte_data == CH_QUOTE) begin
               direct_emit = 1'b1;
               direct_t.kind = KIND_STRING;
               direct_t.offset = 16'(start_ff);
               direct_t.length = len_grow;
               mode_in = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            if (byte_data == CH_NL) mode_in = MODE_IDLE;
         end
         default: begin
            begin_now = 1'b1;
         end
      endcase

      // a new token may start with this byte; whitespace starts none
      begin_emit = 1'b0;
      begin_t = '0;
      begin_t.offset = 16'(pos_ff);
      begin_t.length = 16'd1;
      if (begin_now) begin
         mode_in  = MODE_IDLE;
         start_in = pos_ff;
         len_in   = 16'd1;
         if (byte_data == 8'h20 || byte_data == 8'h09 || byte_data == CH_NL) begin
            mode_in = MODE_IDLE;
         end else if (!pi[4]) begin
            begin_emit = 1'b1;
            begin_t.kind = {2'b00, pi[3:0]};
         end else if (!so[4]) begin
            op_in = byte_data;
            mode_in = MODE_OPER;
         end else if (byte_data == CH_QUOTE) begin
            mode_in = MODE_STRING;
         end else if (is_letter(byte_data)) begin
            prefix_in = PREFIX_BITS'(byte_data);
            mode_in = MODE_WORD;
         end else if (is_numeral(byte_data)) begin
            dot_in = 1'b0;
            mode_in = MODE_NUMBER;
         end else begin
            begin_emit = 1'b1;
            begin_t.kind = KIND_ERROR;
         end
      end

      // assemble the pair for this byte
      pair_data = '0;
      n_second  = 1'b0;
      if (byte_data == 8'h00) begin
         pair_data.first = flush_t;
         pair_data.second.kind = KIND_END;
         pair_data.second.offset = 16'(pos_ff);
         pair_data.second.length = 16'd1;
         pair_data.second.last = 1'b1;
         pair_data.two = flush_tok;
         if (!flush_tok) pair_data.first = pair_data.second;
         n_first = 1'b1;
         n_second = 1'b1;
      end else if (n_first) begin
         pair_data.first = flush_t;
         pair_data.second = begin_t;
         pair_data.second.last = 1'b1;
         pair_data.two = begin_emit;
         if (!begin_emit) pair_data.first.last = 1'b1;
         n_second = begin_emit;
      end else if (direct_emit) begin
         pair_data.first = direct_t;
         pair_data.first.last = 1'b1;
      end else if (begin_emit) begin
         pair_data.first = begin_t;
         pair_data.first.last = 1'b1;
      end
      if (byte_data == 8'h00 && !flush_tok) pair_data.first.last = 1'b1;
      pair_valid = take && (n_first || direct_emit || begin_emit || n_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         op_ff     <= '0;
         prefix_ff <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         pos_ff    <= '0;
         dot_ff    <= 1'b0;
      end else if (take) begin
         if (byte_data == 8'h00) begin
            mode_ff   <= MODE_IDLE;
            op_ff     <= '0;
            prefix_ff <= '0;
            start_ff  <= '0;
            len_ff    <= '0;
            pos_ff    <= '0;
            dot_ff    <= 1'b0;
         end else begin
            mode_ff   <= mode_in;
            op_ff     <= op_in;
            prefix_ff <= prefix_in;
            start_ff  <= start_in;
            len_ff    <= len_in;
            pos_ff    <= pos_ff + 1'b1;
            dot_ff    <= dot_in;
         end
      end
   end

endmodule

@@ rtl/stl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back
// Token queue and output stage: queues token pairs, sends one token a beat
// and keeps the running error count.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pair_valid,
   input  pair_type    pair_data,
   output logic        space_ok,
   output logic        tok_valid,
   output token_type   tok_data,
   output logic [15:0] tok_errors,
   input  logic        tok_ready
);

   pair_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_ABITS-1:0] wr_ff, rd_ff;
   logic [QUEUE_ABITS:0]   count_ff;
   logic                   half_ff;   // first token of head pair already sent
   logic [15:0]            tally_ff, tally_in;
   logic                   push, pop_tok, pop_pair;
   pair_type               head;

   assign head     = queue_ff[rd_ff];
   assign space_ok = (count_ff < (QUEUE_ABITS+1)'(QUEUE_DEPTH));
   assign push     = pair_valid;
   assign tok_valid = (count_ff != '0);
   assign tok_data  = half_ff ? head.second : head.first;
   assign pop_tok   = tok_valid && tok_ready;
   assign pop_pair  = pop_tok && (half_ff || !head.two);

   // error count as seen by the token now on the output
   always_comb begin
      tally_in = tally_ff;
      if (tok_data.kind == KIND_ERROR && tally_ff != TALLY_MAX) tally_in = tally_ff + 16'd1;
      tok_errors = tally_in;
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ff] <= pair_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
         half_ff  <= 1'b0;
         tally_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop_pair) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QUEUE_ABITS+1)'(push) - (QUEUE_ABITS+1)'(pop_pair);
         if (pop_tok) begin
            half_ff  <= !pop_pair;
            tally_ff <= (tok_data.kind == KIND_END) ? 16'd0 : tally_in;
         end
      end
   end

endmodule

@@ rtl/source_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer
// Source text tokenizer, one byte a beat in, one token a beat out.
// ----------------------------------------------------------------------------
// Input channel req_*: one source byte per beat in req_tdata; a zero byte
// ends the text, flushes the pending token and is answered by an END token.
// Result channel rsp_*: one token per beat; rsp_tlast marks the last token
// caused by one input byte. A byte can cause none, one or two tokens.
// Throughput: one byte per cycle while tokens drain as fast; a byte that
// causes two tokens needs two output beats, set by the single output port.
// A token is offered from the registered pair queue, into which it is written when the byte that ends it is taken.
// A four-entry token-pair queue separates the scanner from the output, so a
// stalled receiver stops req_tready only once the queue is full.
// Reset clears scanner, position, error count and the queue.
// ----------------------------------------------------------------------------
module source_token_lexer import stl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // token_kind, token_offset, token_length,
                                    // errors_so_far, zero fill
   output logic        rsp_tlast    // last_of_run
);

   logic      pair_valid, space_ok, tok_valid;
   pair_type  pair_data;
   token_type tok_data;
   logic [15:0] tok_errors;

   stl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_ready (req_tready),
      .pair_valid (pair_valid),
      .pair_data  (pair_data),
      .space_ok   (space_ok)
   );

   stl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pair_valid (pair_valid),
      .pair_data  (pair_data),
      .space_ok   (space_ok),
      .tok_valid  (tok_valid),
      .tok_data   (tok_data),
      .tok_errors (tok_errors),
      .tok_ready  (rsp_tready)
   );

   assign rsp_tvalid = tok_valid;
   assign rsp_tlast  = tok_data.last;
   assign rsp_tdata  = {2'b00, tok_errors, tok_data.length, tok_data.offset, tok_data.kind};

endmodule
